>>> hw/rtl/ati_pkg.sv
// Shared constants for the antiperiodic table interpolation block:
// default sizes, request action codes and field widths. No dependencies.
`timescale 1ns / 1ps

package ati_pkg;

  // default sizes
  localparam int DEF_TABLES   = 8;
  localparam int DEF_POINTS   = 1024;
  localparam int DEF_FLAVORS  = 16;
  localparam int DEF_KEY_BITS = 20;

  // field widths
  localparam int ACTION_W   = 2;
  localparam int FLAVOR_W   = 4;
  localparam int TABLE_ID_W = 3;
  localparam int POINT_W    = 11;
  localparam int SAMPLE_W   = 32;
  localparam int KEY_IN_W   = 22;
  localparam int PIU_W      = 11;
  localparam int FRAC_W     = 16;

  localparam logic [PIU_W-1:0] PIU_RESET = 11'd1024;

  // request actions
  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MAP    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

endpackage

>>> hw/rtl/ati_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module ati_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/antiperiodic_table_interpolation.sv
// Pipelined: one request per cycle sustained while the result side is not stalled by rsp_ready.
// Throughput is set by the sample store being split into even/odd banks, so both
// neighbor samples come out of single-port reads in the same cycle.
// Reset (rst, synchronous): empties the pipeline, marks every flavor pair unmapped and
// sets points_in_use to 1024. The sample store is not cleared; there is no clearing pass.
// Top level of the antiperiodic interpolation block; uses ati_pkg and ati_ram.
`timescale 1ns / 1ps

module antiperiodic_table_interpolation #(
  parameter int TABLES   = ati_pkg::DEF_TABLES,
  parameter int POINTS   = ati_pkg::DEF_POINTS,
  parameter int FLAVORS  = ati_pkg::DEF_FLAVORS,
  parameter int KEY_BITS = ati_pkg::DEF_KEY_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [ati_pkg::PIU_W-1:0]           cfg_data,
  // request channel
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [ati_pkg::ACTION_W-1:0]        action,
  input  logic [ati_pkg::FLAVOR_W-1:0]        flavor_left,
  input  logic [ati_pkg::FLAVOR_W-1:0]        flavor_right,
  input  logic [ati_pkg::TABLE_ID_W-1:0]      table_id,
  input  logic [ati_pkg::POINT_W-1:0]         point_index,
  input  logic signed [ati_pkg::SAMPLE_W-1:0] sample_re,
  input  logic signed [ati_pkg::SAMPLE_W-1:0] sample_im,
  input  logic signed [ati_pkg::KEY_IN_W-1:0] time_key,
  // result channel
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic signed [ati_pkg::SAMPLE_W-1:0] value_re,
  output logic signed [ati_pkg::SAMPLE_W-1:0] value_im,
  output logic                                unmapped
);

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam int TABLE_LEN  = POINTS + 2;
  localparam int SDEPTH     = TABLES * TABLE_LEN;       // samples in the store
  localparam int ADDR_W     = $clog2(SDEPTH);
  localparam int BANK_DEPTH = (SDEPTH + 1) / 2;         // even / odd bank depth
  localparam int BANK_AW    = ADDR_W - 1;
  localparam int MAP_DEPTH  = FLAVORS * FLAVORS;
  localparam int PAIR_W     = $clog2(MAP_DEPTH);
  localparam int IDX_W      = $clog2(TABLE_LEN);
  localparam int KW         = KEY_BITS + 1;             // saturated key 0 .. 2^KEY_BITS
  localparam int SW         = (KEY_BITS + 2 > 23) ? KEY_BITS + 2 : 23;
  localparam int POS_W      = KW + ati_pkg::PIU_W;
  localparam int IDXR_W     = POS_W - KEY_BITS;
  localparam int SMP_W      = ati_pkg::SAMPLE_W;

  localparam logic [SW-1:0] KEY_MAX_V =
    {{(SW - KEY_BITS - 1){1'b0}}, 1'b1, {KEY_BITS{1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [ati_pkg::PIU_W-1:0] points_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= ati_pkg::PIU_RESET;
    end else if (cfg_write) begin
      points_in_use <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or the next one loads.
  // ---------------------------------------------------------------------------
  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v, s7_v;
  logic r1, r2, r3, r4, r5, r6, r7;

  assign r7 = !s7_v || rsp_ready;
  assign r6 = !s6_v || r7;
  assign r5 = !s5_v || r6;
  assign r4 = !s4_v || r5;
  assign r3 = !s3_v || r4;
  assign r2 = !s2_v || r3;
  assign r1 = !s1_v || r2;

  assign req_ready = r1;

  logic req_accept;
  assign req_accept = req_valid && r1;

  // ---------------------------------------------------------------------------
  // Stage 0: decode at accept. Map writes complete here; key fold and clamps.
  // ---------------------------------------------------------------------------
  logic              fl_ok, tid_ok, wr_ok;
  logic [PAIR_W-1:0] pair_idx;
  logic [ADDR_W-1:0] waddr0;
  logic [SW-1:0]     key_ext, key_sh;
  logic [KW-1:0]     key_sat;
  logic [ati_pkg::PIU_W-1:0] n_cl;
  logic              map_we;
  logic [ati_pkg::TABLE_ID_W-1:0] map_rdata;
  logic [MAP_DEPTH-1:0] map_valid;

  always_comb begin
    fl_ok  = (7'(flavor_left) < 7'(FLAVORS)) && (7'(flavor_right) < 7'(FLAVORS));
    tid_ok = 7'(table_id) < 7'(TABLES);
    wr_ok  = tid_ok && (18'(point_index) < 18'(TABLE_LEN));
    pair_idx = PAIR_W'(13'(flavor_left) + 13'(FLAVORS) * 13'(flavor_right));
    waddr0 = ADDR_W'(ADDR_W'(table_id) * ADDR_W'(TABLE_LEN) + ADDR_W'(point_index));

    // negative key: shift by 2^KEY_BITS, then saturate to 0 .. 2^KEY_BITS
    key_ext = {{(SW - ati_pkg::KEY_IN_W){time_key[ati_pkg::KEY_IN_W-1]}}, time_key};
    key_sh  = time_key[ati_pkg::KEY_IN_W-1] ? key_ext + KEY_MAX_V : key_ext;
    if ($signed(key_sh) < 0) begin
      key_sat = '0;
    end else if ($signed(key_sh) > $signed(KEY_MAX_V)) begin
      key_sat = KEY_MAX_V[KW-1:0];
    end else begin
      key_sat = key_sh[KW-1:0];
    end

    if (points_in_use == '0) begin
      n_cl = ati_pkg::PIU_W'(1);
    end else if (17'(points_in_use) > 17'(POINTS)) begin
      n_cl = ati_pkg::PIU_W'(POINTS);
    end else begin
      n_cl = points_in_use;
    end
  end

  assign map_we = req_accept && (action == ati_pkg::ACT_MAP) && fl_ok;

  ati_ram #(
    .WIDTH (ati_pkg::TABLE_ID_W),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (pair_idx),
    .wdata (table_id),
    .re    (r1),
    .raddr (pair_idx),
    .rdata (map_rdata)
  );

  // one flop per pair; cleared at reset so every pair starts unmapped
  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= '0;
    end else if (map_we) begin
      map_valid[pair_idx] <= tid_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1
  // ---------------------------------------------------------------------------
  logic                  s1_look, s1_neg, s1_fbad, s1_mv, s1_wen;
  logic [KW-1:0]         s1_key;
  logic [ati_pkg::PIU_W-1:0] s1_n;
  logic [ADDR_W-1:0]     s1_waddr;
  logic [2*SMP_W-1:0]    s1_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (r1) begin
      s1_v <= req_valid &&
              (action == ati_pkg::ACT_SAMPLE || action == ati_pkg::ACT_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_look  <= action == ati_pkg::ACT_LOOKUP;
      s1_neg   <= time_key[ati_pkg::KEY_IN_W-1];
      s1_fbad  <= !fl_ok;
      s1_mv    <= map_valid[pair_idx];
      s1_wen   <= wr_ok;
      s1_key   <= key_sat;
      s1_n     <= n_cl;
      s1_waddr <= waddr0;
      s1_wdata <= {sample_im, sample_re};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: key * clamped points_in_use
  // ---------------------------------------------------------------------------
  logic                  s2_look, s2_neg, s2_unm, s2_wen;
  logic [POS_W-1:0]      s2_pos;
  logic [ati_pkg::TABLE_ID_W-1:0] s2_tab;
  logic [ADDR_W-1:0]     s2_waddr;
  logic [2*SMP_W-1:0]    s2_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (r2) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      s2_look  <= s1_look;
      s2_neg   <= s1_neg;
      s2_unm   <= s1_fbad || !s1_mv;
      s2_wen   <= s1_wen;
      s2_pos   <= POS_W'(s1_key) * POS_W'(s1_n);
      s2_tab   <= map_rdata;
      s2_waddr <= s1_waddr;
      s2_wdata <= s1_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: index clamp, fraction, sample address. Sample writes retire here,
  // in request order with the lookup reads.
  // ---------------------------------------------------------------------------
  logic [IDXR_W-1:0]        idx_raw;
  logic [IDX_W-1:0]         idx_cl;
  logic [ati_pkg::FRAC_W-1:0] frac16;
  logic [ADDR_W-1:0]        raddr2;

  always_comb begin
    idx_raw = s2_pos[POS_W-1:KEY_BITS];
    if (18'(idx_raw) > 18'(POINTS)) begin
      idx_cl = IDX_W'(POINTS);
    end else begin
      idx_cl = IDX_W'(idx_raw);
    end
    frac16 = ati_pkg::FRAC_W'({s2_pos[KEY_BITS-1:0], {ati_pkg::FRAC_W{1'b0}}} >> KEY_BITS);
    raddr2 = ADDR_W'(ADDR_W'(s2_tab) * ADDR_W'(TABLE_LEN) + ADDR_W'(idx_cl));
  end

  logic                     s3_look, s3_neg, s3_unm, s3_wen;
  logic [ati_pkg::FRAC_W-1:0] s3_frac;
  logic [ADDR_W-1:0]        s3_raddr, s3_waddr;
  logic [2*SMP_W-1:0]       s3_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (r3) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      s3_look  <= s2_look;
      s3_neg   <= s2_neg;
      s3_unm   <= s2_unm;
      s3_wen   <= s2_wen;
      s3_frac  <= frac16;
      s3_raddr <= raddr2;
      s3_waddr <= s2_waddr;
      s3_wdata <= s2_wdata;
    end
  end

  // Even/odd banks: samples a and a+1 always sit in opposite banks.
  // Even bank reads row (a+1)/2, odd bank reads row a/2.
  logic [ADDR_W-1:0]  raddr_p1;
  logic               smp_we;
  logic [2*SMP_W-1:0] bank0_rdata, bank1_rdata;

  assign raddr_p1 = s3_raddr + ADDR_W'(1);
  assign smp_we   = s3_v && !s3_look && s3_wen && r4;

  ati_ram #(
    .WIDTH (2 * SMP_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_even (
    .clk   (clk),
    .we    (smp_we && !s3_waddr[0]),
    .waddr (s3_waddr[ADDR_W-1:1]),
    .wdata (s3_wdata),
    .re    (r4),
    .raddr (raddr_p1[ADDR_W-1:1]),
    .rdata (bank0_rdata)
  );

  ati_ram #(
    .WIDTH (2 * SMP_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_odd (
    .clk   (clk),
    .we    (smp_we && s3_waddr[0]),
    .waddr (s3_waddr[ADDR_W-1:1]),
    .wdata (s3_wdata),
    .re    (r4),
    .raddr (s3_raddr[ADDR_W-1:1]),
    .rdata (bank1_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 4: bank data arrives; only lookups travel on.
  // ---------------------------------------------------------------------------
  logic                     s4_neg, s4_unm, s4_odd;
  logic [ati_pkg::FRAC_W-1:0] s4_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (r4) begin
      s4_v <= s3_v && s3_look;
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      s4_neg  <= s3_neg;
      s4_unm  <= s3_unm;
      s4_odd  <= s3_raddr[0];
      s4_frac <= s3_frac;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: neighbor difference
  // ---------------------------------------------------------------------------
  logic [2*SMP_W-1:0] w0, w1;

  assign w0 = s4_odd ? bank1_rdata : bank0_rdata;
  assign w1 = s4_odd ? bank0_rdata : bank1_rdata;

  logic                     s5_neg, s5_unm;
  logic [ati_pkg::FRAC_W-1:0] s5_frac;
  logic signed [SMP_W-1:0]  s5_a_re, s5_a_im;
  logic signed [SMP_W:0]    s5_d_re, s5_d_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (r5) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      s5_neg  <= s4_neg;
      s5_unm  <= s4_unm;
      s5_frac <= s4_frac;
      s5_a_re <= $signed(w0[SMP_W-1:0]);
      s5_a_im <= $signed(w0[2*SMP_W-1:SMP_W]);
      s5_d_re <= $signed({w1[SMP_W-1], w1[SMP_W-1:0]}) -
                 $signed({w0[SMP_W-1], w0[SMP_W-1:0]});
      s5_d_im <= $signed({w1[2*SMP_W-1], w1[2*SMP_W-1:SMP_W]}) -
                 $signed({w0[2*SMP_W-1], w0[2*SMP_W-1:SMP_W]});
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: fraction * difference
  // ---------------------------------------------------------------------------
  localparam int PROD_W = SMP_W + 1 + ati_pkg::FRAC_W + 1;

  logic signed [ati_pkg::FRAC_W:0] frac_s;
  assign frac_s = $signed({1'b0, s5_frac});

  logic                    s6_neg, s6_unm;
  logic signed [SMP_W-1:0] s6_a_re, s6_a_im;
  logic signed [PROD_W-1:0] s6_p_re, s6_p_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (r6) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (r6) begin
      s6_neg  <= s5_neg;
      s6_unm  <= s5_unm;
      s6_a_re <= s5_a_re;
      s6_a_im <= s5_a_im;
      s6_p_re <= frac_s * s5_d_re;
      s6_p_im <= frac_s * s5_d_im;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7 (output register): a*2^16 + product, floor by 2^16, fold sign.
  // Negating the most negative value saturates.
  // ---------------------------------------------------------------------------
  function automatic logic [SMP_W-1:0] finish(input logic signed [SMP_W-1:0] a,
                                              input logic signed [PROD_W-1:0] p,
                                              input logic ng);
    logic signed [PROD_W:0] sum;
    logic [SMP_W-1:0]       q;
    sum = $signed({{(PROD_W + 1 - SMP_W - ati_pkg::FRAC_W){a[SMP_W-1]}}, a,
                   {ati_pkg::FRAC_W{1'b0}}}) + $signed({p[PROD_W-1], p});
    q   = sum[SMP_W+ati_pkg::FRAC_W-1:ati_pkg::FRAC_W];
    if (!ng) begin
      return q;
    end else if (q == {1'b1, {(SMP_W - 1){1'b0}}}) begin
      return {1'b0, {(SMP_W - 1){1'b1}}};
    end else begin
      return -q;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (r7) begin
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (r7) begin
      unmapped <= s6_unm;
      value_re <= s6_unm ? '0 : $signed(finish(s6_a_re, s6_p_re, s6_neg));
      value_im <= s6_unm ? '0 : $signed(finish(s6_a_im, s6_p_im, s6_neg));
    end
  end

  assign rsp_valid = s7_v;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an unmapped pair always answers zero
  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && unmapped |-> value_re == '0 && value_im == '0)
    else $error("unmapped result carries a nonzero value");

  // back-pressure reaches the request side only when every stage is full
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> s1_v && s2_v && s3_v && s4_v && s5_v && s6_v && s7_v)
    else $error("request stalled with a bubble in the pipeline");

  // a held read stage keeps its address, so the bank data stays matched
  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    s3_v && !r4 |=> s3_v && $stable(s3_raddr))
    else $error("stalled lookup lost its sample address");

  // both neighbor samples of a mapped lookup lie inside the store
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    s3_v && s3_look && !s3_unm |-> 32'(s3_raddr) < 32'(SDEPTH - 1))
    else $error("lookup sample address outside the store");

  // sample writes never coincide with a lookup in the read stage
  a_write_kind: assert property (@(posedge clk) disable iff (rst)
    smp_we |-> s3_v && !s3_look && !s4_v || smp_we && s3_v && !s3_look)
    else $error("sample write issued by a lookup");

endmodule

>>> dv/tb_antiperiodic_table_interpolation.sv
`timescale 1ns / 1ps
// Self-checking bench for antiperiodic_table_interpolation: directed and random requests,
// an in-order predictor of every lookup and a field-by-field check of each result.
// Depends on ati_pkg and the block's RTL; needs no files or arguments.

module tb_antiperiodic_table_interpolation;
  import ati_pkg::*;

  localparam int     TABLE_LEN     = DEF_POINTS + 2;
  localparam int     STORE_DEPTH   = DEF_TABLES * TABLE_LEN;
  localparam int     PAIRS         = DEF_FLAVORS * DEF_FLAVORS;
  localparam longint KEY_SPAN      = longint'(1) << DEF_KEY_BITS;
  localparam longint S32_MIN       = -64'sd2147483648;
  localparam longint S32_MAX       = 64'sd2147483647;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
  // action code 3 is not decoded by the block: accepted, no effect, no result
  localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;   // pipeline is 7 deep
  localparam int MISS_REPORTS  = 10;

  typedef struct {
    logic [ACTION_W-1:0]        action;
    logic [FLAVOR_W-1:0]        flavor_left;
    logic [FLAVOR_W-1:0]        flavor_right;
    logic [TABLE_ID_W-1:0]      table_id;
    logic [POINT_W-1:0]         point_index;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
    logic signed [KEY_IN_W-1:0] time_key;
  } request_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value_re;
    logic signed [SAMPLE_W-1:0] value_im;
    logic                       unmapped;
  } lookup_value_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                        clk;
  logic                        rst          = 1'b1;
  logic                        cfg_write    = 1'b0;
  logic [PIU_W-1:0]            cfg_data     = '0;
  logic                        req_valid    = 1'b0;
  logic                        req_ready;
  logic [ACTION_W-1:0]         action       = '0;
  logic [FLAVOR_W-1:0]         flavor_left  = '0;
  logic [FLAVOR_W-1:0]         flavor_right = '0;
  logic [TABLE_ID_W-1:0]       table_id     = '0;
  logic [POINT_W-1:0]          point_index  = '0;
  logic signed [SAMPLE_W-1:0]  sample_re    = '0;
  logic signed [SAMPLE_W-1:0]  sample_im    = '0;
  logic signed [KEY_IN_W-1:0]  time_key     = '0;
  logic                        rsp_valid;
  logic                        rsp_ready    = 1'b0;
  logic signed [SAMPLE_W-1:0]  value_re;
  logic signed [SAMPLE_W-1:0]  value_im;
  logic                        unmapped;

  antiperiodic_table_interpolation u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .action       (action),
    .flavor_left  (flavor_left),
    .flavor_right (flavor_right),
    .table_id     (table_id),
    .point_index  (point_index),
    .sample_re    (sample_re),
    .sample_im    (sample_im),
    .time_key     (time_key),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .value_re     (value_re),
    .value_im     (value_im),
    .unmapped     (unmapped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state, advanced at each accepted request / config write.
  // Sample words are {im, re}. Pair index is left + FLAVORS * right.
  // ---------------------------------------------------------------------------
  logic [2*SAMPLE_W-1:0] sample_mem [STORE_DEPTH];
  bit                    link_valid [PAIRS];
  logic [TABLE_ID_W-1:0] link_table [PAIRS];
  logic [PIU_W-1:0]      piu_now = PIU_RESET;

  // Stimulus-side view of the same state, used while the request list is built so
  // that no lookup ever touches a sample that was never written.
  bit                    gen_written [STORE_DEPTH];
  bit                    gen_linked  [PAIRS];
  logic [TABLE_ID_W-1:0] gen_table   [PAIRS];
  int unsigned           gen_piu = PIU_RESET;
  int unsigned           linked_pairs [$];

  request_t      req_backlog [$];   // built by the sequencer, drained by the driver
  lookup_value_t due_results [$];   // predicted lookup results, oldest first
  request_t      head;
  lookup_value_t owed;

  int unsigned sent_count  = 0;
  int unsigned taken_count = 0;
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap    = 0;
  int unsigned take_gap    = 0;
  bit          req_taken   = 1'b0;  // request handshake at the last rising edge
  bit          calm_tail   = 1'b0;  // no idling on either side in the final phase

  // ---------------------------------------------------------------------------
  // Lookup arithmetic
  // ---------------------------------------------------------------------------
  // register 0 behaves as 1, anything above POINTS as POINTS
  function automatic longint clamp_points(int unsigned piu);
    if (piu < 1) return 1;
    if (piu > DEF_POINTS) return DEF_POINTS;
    return piu;
  endfunction

  // Key -> sample index, 16-bit fraction and negate flag. Negative keys wrap up by
  // KEY_SPAN (antiperiodic half), then the key saturates to 0 .. KEY_SPAN.
  function automatic void locate_key(input logic signed [KEY_IN_W-1:0] raw,
                                     input int unsigned piu,
                                     output int unsigned idx,
                                     output int unsigned frac16,
                                     output bit flip);
    longint k;
    longint pos;
    k    = raw;
    flip = (k < 0);
    if (flip) k += KEY_SPAN;
    if (k < 0) k = 0;
    if (k > KEY_SPAN) k = KEY_SPAN;
    pos    = k * clamp_points(piu);
    idx    = int'(pos >> DEF_KEY_BITS);
    frac16 = int'((pos & (KEY_SPAN - 1)) >> (DEF_KEY_BITS - FRAC_W));
    if (idx > DEF_POINTS) idx = DEF_POINTS;
  endfunction

  // floor(((65536 - f) * lo + f * hi) / 65536), negated with saturation when flip is set
  function automatic logic signed [SAMPLE_W-1:0] blend(input logic [SAMPLE_W-1:0] lo,
                                                       input logic [SAMPLE_W-1:0] hi,
                                                       input int unsigned frac16,
                                                       input bit flip);
    longint a;
    longint b;
    longint s;
    a = $signed(lo);
    b = $signed(hi);
    s = (a * 65536 + longint'(frac16) * (b - a)) >>> 16;
    if (flip) s = (s == S32_MIN) ? S32_MAX : -s;
    return s[SAMPLE_W-1:0];
  endfunction

  // Flavors are 4 bits wide with 16 flavors, so an out-of-range pair cannot occur here.
  function automatic lookup_value_t predict_lookup(input logic [FLAVOR_W-1:0] fl,
                                                   input logic [FLAVOR_W-1:0] fr,
                                                   input logic signed [KEY_IN_W-1:0] key);
    lookup_value_t res;
    int unsigned   pair;
    int unsigned   idx;
    int unsigned   frac16;
    int unsigned   base;
    bit            flip;
    logic [2*SAMPLE_W-1:0] w0;
    logic [2*SAMPLE_W-1:0] w1;
    res.value_re = '0;
    res.value_im = '0;
    res.unmapped = 1'b1;
    pair = fl + DEF_FLAVORS * fr;
    if (!link_valid[pair]) return res;
    locate_key(key, piu_now, idx, frac16, flip);
    base = link_table[pair] * TABLE_LEN + idx;
    w0 = sample_mem[base];
    w1 = sample_mem[base + 1];
    res.value_re = blend(w0[SAMPLE_W-1:0], w1[SAMPLE_W-1:0], frac16, flip);
    res.value_im = blend(w0[2*SAMPLE_W-1:SAMPLE_W], w1[2*SAMPLE_W-1:SAMPLE_W], frac16, flip);
    res.unmapped = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request building
  // ---------------------------------------------------------------------------
  // fields that the action does not use still carry random values
  function automatic request_t filler();
    request_t r;
    r.action       = ACT_LOOKUP;
    r.flavor_left  = $urandom_range(0, DEF_FLAVORS - 1);
    r.flavor_right = $urandom_range(0, DEF_FLAVORS - 1);
    r.table_id     = $urandom_range(0, DEF_TABLES - 1);
    r.point_index  = $urandom_range(0, (1 << POINT_W) - 1);
    r.sample_re    = $urandom;
    r.sample_im    = $urandom;
    r.time_key     = $urandom;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 11))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // mostly inside the nominal range, with edges and full-width values mixed in
  function automatic logic signed [KEY_IN_W-1:0] rand_key();
    longint k;
    case ($urandom_range(0, 19))
      0:       k = 0;
      1:       k = KEY_SPAN;
      2:       k = -KEY_SPAN;
      3:       k = -1;
      4:       k = KEY_SPAN - 1;
      5:       k = KEY_SPAN + 1;
      6:       k = -KEY_SPAN - 1;
      7, 8:    k = $urandom;
      default: k = longint'($urandom_range(0, 2 * int'(KEY_SPAN))) - (KEY_SPAN - 1);
    endcase
    return k[KEY_IN_W-1:0];
  endfunction

  task automatic post(input request_t r);
    int unsigned pair;
    case (r.action)
      ACT_SAMPLE: begin
        if (r.point_index < TABLE_LEN) gen_written[r.table_id * TABLE_LEN + r.point_index] = 1'b1;
      end
      ACT_MAP: begin
        pair = r.flavor_left + DEF_FLAVORS * r.flavor_right;
        if (!gen_linked[pair]) linked_pairs.push_back(pair);
        gen_linked[pair] = 1'b1;
        gen_table[pair]  = r.table_id;
      end
      default: ;
    endcase
    req_backlog.push_back(r);
    sent_count++;
  endtask

  task automatic post_sample(input int unsigned tid, input int unsigned pidx,
                             input logic signed [SAMPLE_W-1:0] re,
                             input logic signed [SAMPLE_W-1:0] im);
    request_t r;
    r = filler();
    r.action      = ACT_SAMPLE;
    r.table_id    = tid;
    r.point_index = pidx;
    r.sample_re   = re;
    r.sample_im   = im;
    post(r);
  endtask

  task automatic post_link(input int unsigned fl, input int unsigned fr, input int unsigned tid);
    request_t r;
    r = filler();
    r.action       = ACT_MAP;
    r.flavor_left  = fl;
    r.flavor_right = fr;
    r.table_id     = tid;
    post(r);
  endtask

  // Writes any of the two neighbor samples the lookup will read that are still unset.
  task automatic post_lookup(input int unsigned fl, input int unsigned fr,
                             input logic signed [KEY_IN_W-1:0] key);
    request_t    r;
    int unsigned pair;
    int unsigned idx;
    int unsigned frac16;
    bit          flip;
    pair = fl + DEF_FLAVORS * fr;
    if (gen_linked[pair]) begin
      locate_key(key, gen_piu, idx, frac16, flip);
      for (int unsigned p = idx; p <= idx + 1; p++) begin
        if (!gen_written[gen_table[pair] * TABLE_LEN + p])
          post_sample(gen_table[pair], p, rand_sample(), rand_sample());
      end
    end
    r = filler();
    r.action       = ACT_LOOKUP;
    r.flavor_left  = fl;
    r.flavor_right = fr;
    r.time_key     = key;
    post(r);
  endtask

  task automatic post_reserved();
    request_t r;
    r = filler();
    r.action = ACT_RESERVED;
    post(r);
  endtask

  task automatic directed_checks();
    post_lookup(3, 5, 0);                         // nothing mapped after reset
    post_reserved();
    post_sample(2, TABLE_LEN, SAMPLE_MAX, SAMPLE_MIN);   // index past the table: dropped
    post_sample(5, (1 << POINT_W) - 1, rand_sample(), rand_sample());
    post_link(15, 0, 7);
    post_link(0, 15, 0);
    // most negative sample under a negated lookup saturates to the maximum
    post_sample(7, 0, SAMPLE_MIN, SAMPLE_MAX);
    post_lookup(15, 0, -KEY_SPAN);
    post_lookup(15, 0, 0);
    post_lookup(0, 15, KEY_SPAN);                 // last interval, top sample pair
    post_lookup(0, 15, KEY_SPAN + 1);             // saturates high
    post_lookup(0, 15, 2 * KEY_SPAN - 1);
    post_lookup(0, 15, -2 * KEY_SPAN);            // saturates to 0 after the wrap
    post_lookup(0, 15, -1);
    post_lookup(0, 15, 1);
    post_lookup(0, 15, KEY_SPAN / 3);
    post_link(15, 0, 3);                          // remap an existing pair
    post_lookup(15, 0, 12345);
    post_lookup(15, 15, rand_key());
  endtask

  // Mostly lookups on mapped pairs with writes interleaved; a few unmapped pairs,
  // dropped writes and reserved actions as noise. Only effective requests count.
  task automatic random_phase(input int unsigned rounds);
    int unsigned done;
    int unsigned pick;
    int unsigned pair;
    int unsigned pidx;
    int unsigned span;
    done = 0;
    while (done < rounds) begin
      pick = $urandom_range(0, 99);
      span = clamp_points(gen_piu);
      if (pick < 50) begin
        if (linked_pairs.size() > 0 && $urandom_range(0, 9) < 8)
          pair = linked_pairs[$urandom_range(0, linked_pairs.size() - 1)];
        else
          pair = $urandom_range(0, PAIRS - 1);
        post_lookup(pair % DEF_FLAVORS, pair / DEF_FLAVORS, rand_key());
        done++;
      end else if (pick < 70) begin
        pidx = ($urandom_range(0, 9) < 9) ? $urandom_range(0, span + 1)
                                          : $urandom_range(0, (1 << POINT_W) - 1);
        post_sample($urandom_range(0, DEF_TABLES - 1), pidx, rand_sample(), rand_sample());
        if (pidx < TABLE_LEN) done++;
      end else if (pick < 82) begin
        pair = $urandom_range(0, PAIRS - 1);
        post_link(pair % DEF_FLAVORS, pair / DEF_FLAVORS, $urandom_range(0, DEF_TABLES - 1));
        done++;
      end else if (pick < 95) begin
        // map a pair, then hit it a few times right behind the map write
        pair = $urandom_range(0, PAIRS - 1);
        post_link(pair % DEF_FLAVORS, pair / DEF_FLAVORS, $urandom_range(0, DEF_TABLES - 1));
        repeat ($urandom_range(2, 4)) post_lookup(pair % DEF_FLAVORS, pair / DEF_FLAVORS, rand_key());
        done += 3;
      end else begin
        post_reserved();
      end
    end
  endtask

  // Block idle: all requests taken, all results back, then let the pipeline empty.
  task automatic settle();
    while (taken_count != sent_count || due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_points(input int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    gen_piu = value;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: changes on the falling edge. A presented request holds until the
  // rising edge that takes it; between requests it may drop req_valid at random.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && !(req_valid && !req_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(0, 17);
        req_valid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        head = req_backlog.pop_front();
        req_valid    <= 1'b1;
        action       <= head.action;
        flavor_left  <= head.flavor_left;
        flavor_right <= head.flavor_right;
        table_id     <= head.table_id;
        point_index  <= head.point_index;
        sample_re    <= head.sample_re;
        sample_im    <= head.sample_im;
        time_key     <= head.time_key;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure, same burst shape as the driver
  always @(negedge clk) begin
    if (take_gap > 0) begin
      take_gap--;
      rsp_ready <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 15) == 0) begin
      take_gap = $urandom_range(0, 17);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on each rising edge, advance the predictor with the taken request and
  // compare any taken result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (cfg_write) piu_now = cfg_data;
      req_taken = req_valid && req_ready;
      if (req_taken) begin
        taken_count++;
        case (action)
          ACT_SAMPLE: begin
            if (point_index < TABLE_LEN)
              sample_mem[table_id * TABLE_LEN + point_index] = {sample_im, sample_re};
          end
          ACT_MAP: begin
            link_valid[flavor_left + DEF_FLAVORS * flavor_right] = (table_id < DEF_TABLES);
            link_table[flavor_left + DEF_FLAVORS * flavor_right] = table_id;
          end
          ACT_LOOKUP: begin
            due_results.push_back(predict_lookup(flavor_left, flavor_right, time_key));
          end
          default: ;   // reserved action: no effect
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          err_count++;
          if (err_count <= MISS_REPORTS)
            $display("result with no lookup outstanding: re %h im %h unmapped %b",
                     value_re, value_im, unmapped);
        end else begin
          owed = due_results.pop_front();
          if (value_re !== owed.value_re || value_im !== owed.value_im ||
              unmapped !== owed.unmapped) begin
            err_count++;
            if (err_count <= MISS_REPORTS)
              $display("lookup mismatch: exp re %h im %h unmapped %b, got re %h im %h unmapped %b",
                       owed.value_re, owed.value_im, owed.unmapped,
                       value_re, value_im, unmapped);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_antiperiodic_table_interpolation: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: directed checks at the reset setting of points_in_use, then one
  // random phase per register setting (0 and values above POINTS included).
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned piu_plan [8];
    piu_plan = '{0, 1, 2047, 1025, 5, 2, 333, 1024};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_checks();
    random_phase(60);
    settle();
    for (int i = 0; i < 8; i++) begin
      write_points(piu_plan[i]);
      if (i == 7) calm_tail = 1'b1;
      random_phase(55);
      settle();
    end

    // catch any stray result after the last one expected
    repeat (20) @(negedge clk);
    if (err_count == 0)
      $display("tb_antiperiodic_table_interpolation: clean");
    else
      $display("tb_antiperiodic_table_interpolation: errors");
    $finish;
  end

endmodule
